// ===== hw/rtl/url_percent_codec_top_defines.svh =====
// ----------------------------------------------------------------------------
// url percent codec assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_CODEC_TOP_DEFINES_SVH
`define URL_PERCENT_CODEC_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check sampled on aclk, masked while in reset
`define UPC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("url percent codec check failed");
// check sampled on aclk, also active during reset
`define UPC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("url percent codec check failed");
`else
`define UPC_ASSERT(lbl, prop)
`define UPC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/upc_pkg.sv =====
// ----------------------------------------------------------------------------
// upc_pkg
// shared types, character constants and helper functions of the url codec
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package upc_pkg;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // register map
    localparam int unsigned PADDR_W  = 3;
    localparam logic        REG_MODE = 1'b0;
    localparam logic        MODE_ENC = 1'b0;
    localparam logic        MODE_DEC = 1'b1;

    // escape tracking in decode mode
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HIGH = 3'b100
    } phase_t;

    typedef struct packed {
        logic mode;
        logic clr;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } res_t;

    typedef struct packed {
        logic [1:0]       cnt;
        res_t [2:0]       res;
        phase_t           phase;
        logic [7:0]       held;
    } xlate_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return is_digit(c) || ((c >= CH_UA) && (c <= CH_UZ)) ||
               ((c >= CH_LA) && (c <= CH_LZ)) || (c == CH_DASH) ||
               (c == CH_UNDER) || (c == CH_DOT) || (c == CH_TILDE);
    endfunction

    // unchecked hex value of one character, wraps modulo 256
    function automatic logic [7:0] nibble_of(input logic [7:0] c);
        logic [7:0] f;
        f = c;
        if ((c >= CH_UA) && (c <= CH_UZ)) begin
            f = c + 8'd32;
        end
        if (is_digit(c)) begin
            return c - 8'd48;
        end
        return f - 8'd87;
    endfunction

endpackage

// ===== hw/rtl/upc_cfg.sv =====
// ----------------------------------------------------------------------------
// upc_cfg
// apb register slave holding the codec mode
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upc_cfg import upc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic mode_reg;
    logic mode_next;
    logic wr_mode;

    assign pready  = 1'b1;
    assign wr_mode = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
    assign mode_next = wr_mode ? pwdata[0] : mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ENC;
        end else begin
            mode_reg <= mode_next;
        end
    end

    assign prdata   = (paddr[2] == REG_MODE) ? {31'd0, mode_reg} : 32'd0;
    assign cfg.mode = mode_reg;
    assign cfg.clr  = wr_mode;

endmodule

// ===== hw/rtl/upc_xlate.sv =====
// ----------------------------------------------------------------------------
// upc_xlate
// combinational translation of one character into up to three results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upc_xlate import upc_pkg::*; (
    input  logic       mode,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  phase_t     phase,
    input  logic [7:0] held,
    output xlate_t     xo
);

    logic [7:0] dec_byte;
    logic       dec_have;
    logic [7:0] hi_nib;

    always_comb begin
        xo       = '0;
        xo.phase = phase;
        xo.held  = held;
        dec_byte = 8'd0;
        dec_have = 1'b0;
        hi_nib   = nibble_of(held);

        if (mode == MODE_ENC) begin
            if (is_unreserved(in_byte)) begin
                xo.cnt    = 2'd1;
                xo.res[0] = '{data: in_byte, valid: 1'b1, last: in_last};
            end else if (in_byte == CH_SPACE) begin
                xo.cnt    = 2'd1;
                xo.res[0] = '{data: CH_PLUS, valid: 1'b1, last: in_last};
            end else begin
                xo.cnt    = 2'd3;
                xo.res[0] = '{data: CH_PCT, valid: 1'b1, last: 1'b0};
                xo.res[1] = '{data: HEX_DIGITS[in_byte[7:4]], valid: 1'b1, last: 1'b0};
                xo.res[2] = '{data: HEX_DIGITS[in_byte[3:0]], valid: 1'b1,
                              last: in_last};
            end
        end else begin
            if ((phase == PH_PCT) && !in_last) begin
                xo.held  = in_byte;
                xo.phase = PH_HIGH;
            end else if (phase == PH_HIGH) begin
                dec_byte = {hi_nib[3:0], 4'd0} | nibble_of(in_byte);
                dec_have = 1'b1;
                xo.phase = PH_IDLE;
                xo.held  = 8'd0;
            end else begin
                // plain character, or one that follows a cut-off escape
                xo.phase = PH_IDLE;
                xo.held  = 8'd0;
                if (in_byte == CH_PCT) begin
                    if (!in_last) begin
                        xo.phase = PH_PCT;
                    end
                end else if (in_byte == CH_PLUS) begin
                    dec_byte = CH_SPACE;
                    dec_have = 1'b1;
                end else begin
                    dec_byte = in_byte;
                    dec_have = 1'b1;
                end
            end

            if (dec_have) begin
                xo.cnt    = 2'd1;
                xo.res[0] = '{data: dec_byte, valid: 1'b1, last: in_last};
            end else if (in_last) begin
                // empty closing result
                xo.cnt    = 2'd1;
                xo.res[0] = '{data: 8'd0, valid: 1'b0, last: 1'b1};
            end
        end

        if (in_last) begin
            xo.phase = PH_IDLE;
            xo.held  = 8'd0;
        end
    end

endmodule

// ===== hw/rtl/upc_outbuf.sv =====
// ----------------------------------------------------------------------------
// upc_outbuf
// result register holding up to three results, drained one per transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upc_outbuf import upc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  xlate_t     xi,
    output logic       free,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_valid,
    output logic       m_out_last
);

    res_t       res_reg [3];
    logic [1:0] rem_reg;
    logic [1:0] rem_next;
    logic [1:0] ptr_reg;
    logic [1:0] ptr_next;
    logic       pop;

    assign m_valid = (rem_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign free    = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && m_ready);

    always_comb begin
        rem_next = rem_reg;
        ptr_next = ptr_reg;
        if (load) begin
            rem_next = xi.cnt;
            ptr_next = 2'd0;
        end else if (pop) begin
            rem_next = rem_reg - 2'd1;
            ptr_next = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg[0] <= xi.res[0];
            res_reg[1] <= xi.res[1];
            res_reg[2] <= xi.res[2];
        end
    end

    always_comb begin
        case (ptr_reg)
            2'd0:    {m_out_byte, m_out_valid, m_out_last} = res_reg[0];
            2'd1:    {m_out_byte, m_out_valid, m_out_last} = res_reg[1];
            2'd2:    {m_out_byte, m_out_valid, m_out_last} = res_reg[2];
            default: {m_out_byte, m_out_valid, m_out_last} = res_reg[2];
        endcase
    end

endmodule

// ===== hw/rtl/url_percent_codec_top.sv =====
// ----------------------------------------------------------------------------
// url_percent_codec_top
// streaming url form encoder and decoder, one character per input transfer
// ----------------------------------------------------------------------------
// usage
//   s_ channel carries one string character per transfer, s_in_last on the
//   final character. m_ channel carries one result per transfer: a byte with
//   m_out_valid set, or, at a string end that yields nothing, an empty result
//   with m_out_valid low and m_out_last high.
//   the apb port holds one register (mode, byte address 0): 0 encodes,
//   1 decodes. writing it also drops any half-seen escape. write it only
//   while no characters are in flight.
//   a character passes the input register, then the result register, before
//   its first result can be taken.
//   throughput: one character per cycle while each yields at most one
//   result and the receiver takes every result; an escaped character in
//   encode mode holds the result register for three transfers, so the rate
//   is then set by the one-byte result channel.
//   when the receiver stalls, results wait in the result register and one
//   more character waits in the input register before s_ready drops.
//   reset (aresetn low, synchronous) empties both registers, selects encode
//   mode and clears the decode escape state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "url_percent_codec_top_defines.svh"

module url_percent_codec_top import upc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // character input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    input  logic               s_in_last,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_out_valid,
    output logic               m_out_last
);

    cfg_t       cfg;
    xlate_t     xo;

    // input register
    logic       ival_reg;
    logic       ival_next;
    logic [7:0] ibyte_reg;
    logic       ilast_reg;

    // decode escape state
    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;

    logic       buf_free;
    logic       advance;
    logic       s_xfer;

    upc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // item moves into the result register once the previous results drain
    assign advance = ival_reg && buf_free;
    assign s_ready = !ival_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    assign ival_next = s_ready ? s_valid : ival_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ival_reg <= 1'b0;
        end else begin
            ival_reg <= ival_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            ibyte_reg <= s_in_byte;
            ilast_reg <= s_in_last;
        end
    end

    upc_xlate u_xlate (
        .mode    (cfg.mode),
        .in_byte (ibyte_reg),
        .in_last (ilast_reg),
        .phase   (phase_reg),
        .held    (held_reg),
        .xo      (xo)
    );

    // escape state follows the item that leaves the input register
    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (cfg.clr) begin
            phase_next = PH_IDLE;
            held_next  = 8'd0;
        end else if (advance) begin
            phase_next = xo.phase;
            held_next  = xo.held;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    upc_outbuf u_outbuf (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .xi          (xo),
        .free        (buf_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_valid (m_out_valid),
        .m_out_last  (m_out_last)
    );

    // an accepted character always lands in the input register
    `UPC_ASSERT(a_xfer_lands, s_xfer |=> ival_reg)
    // escape tracking is only ever active in decode mode
    `UPC_ASSERT(a_enc_idle, (cfg.mode == MODE_ENC) |-> (phase_reg == PH_IDLE))
    // escape state stays one-hot
    `UPC_ASSERT(a_phase_onehot, $onehot(phase_reg))
    // a result without a byte only closes a string
    `UPC_ASSERT(a_empty_is_last, (m_valid && !m_out_valid) |-> m_out_last)
    // register port never inserts wait states, in reset too
    `UPC_ASSERT_ALWAYS(a_pready_high, pready)

endmodule
